FILE: rtl/bpr_factor_sgd_update_assert.svh
// ----------------------------------------------------------------------------
// BPR factor SGD update - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BPR_FACTOR_SGD_UPDATE_ASSERT_SVH
`define BPR_FACTOR_SGD_UPDATE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must never hold
`define BFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Types, codes, defaults and the sigmoid table of the BPR SGD update block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfs_pkg;

  localparam int NUM_USERS_DEF  = 1024;
  localparam int NUM_ITEMS_DEF  = 4096;
  localparam int FACTOR_DIM_DEF = 16;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [2:0] FUNC_TRAIN     = 3'd0;
  localparam logic [2:0] FUNC_LOAD_USER = 3'd1;
  localparam logic [2:0] FUNC_LOAD_ITEM = 3'd2;
  localparam logic [2:0] FUNC_READ_USER = 3'd3;
  localparam logic [2:0] FUNC_READ_ITEM = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_REG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_REG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd3;

  localparam logic [15:0] LEARN_RATE_RST = 16'd655;
  localparam logic [15:0] USER_REG_RST   = 16'd655;
  localparam logic [15:0] ITEM_REG_RST   = 16'd655;
  localparam logic [14:0] MARGIN_RST     = 15'd0;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_BASE, S_LOAD, S_READ, S_READ_W,
    S_DOT_A, S_DOT_B, S_DOT_C, S_DOT_D, S_DIFF, S_SAT, S_SIGM, S_COEF,
    S_UPD_A, S_UPD_B, S_UPD_C, S_MV1, S_MV2, S_MV3, S_MVW,
    S_ITM_A, S_ITM_B, S_ITM_N, S_ITM_NB, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_USER, MODE_POS, MODE_NEG
  } mode_t;

  // 1/(1+e^d) in Q0.16 at d = -8..8
  function automatic logic [16:0] sig_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65514;
      5'd1:  v = 17'd65476;
      5'd2:  v = 17'd65374;
      5'd3:  v = 17'd65097;
      5'd4:  v = 17'd64357;
      5'd5:  v = 17'd62428;
      5'd6:  v = 17'd57724;
      5'd7:  v = 17'd47911;
      5'd8:  v = 17'd32768;
      5'd9:  v = 17'd17625;
      5'd10: v = 17'd7812;
      5'd11: v = 17'd3108;
      5'd12: v = 17'd1179;
      5'd13: v = 17'd439;
      5'd14: v = 17'd162;
      5'd15: v = 17'd60;
      5'd16: v = 17'd22;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bfs_ram.sv
// ----------------------------------------------------------------------------
// bfs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bfs_move.sv
// ----------------------------------------------------------------------------
// bfs_move
// Three-stage SGD element update: w' = sat16(w - rnd(lr * (c*x + 2*reg*w))).
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_move (
  input  wire logic               clk,
  input  wire logic signed [17:0] coef,
  input  wire logic signed [16:0] x,
  input  wire logic signed [15:0] w,
  input  wire logic        [15:0] rg,
  input  wire logic        [15:0] lr,
  output logic signed      [15:0] w_new
);

  logic signed [34:0] t_s1;
  logic signed [32:0] rw_s1;
  logic signed [15:0] w_s1;
  logic signed [35:0] g_s2;
  logic signed [15:0] w_s2;
  logic signed [52:0] prod_s3;
  logic signed [15:0] w_s3;

  always_ff @(posedge clk) begin
    t_s1    <= coef * x;
    rw_s1   <= $signed({1'b0, rg}) * w;
    w_s1    <= w;
    g_s2    <= 36'(t_s1) + (36'(rw_s1) <<< 1);
    w_s2    <= w_s1;
    prod_s3 <= $signed({1'b0, lr}) * g_s2;
    w_s3    <= w_s2;
  end

  always_comb begin
    logic signed [53:0] rnd;
    logic signed [21:0] delta;
    logic signed [22:0] res;
    rnd   = 54'(prod_s3) + (54'sd1 <<< 31);
    delta = 22'(rnd >>> 32);
    res   = 23'(w_s3) - 23'(delta);
    if (res > 23'sd32767) begin
      w_new = 16'sh7fff;
    end else if (res < -23'sd32768) begin
      w_new = 16'sh8000;
    end else begin
      w_new = res[15:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpr_factor_sgd_update.sv
// Throughput: one request at a time; the next can be taken in the cycle after the result is
// registered; set by the single read port of each factor RAM, one element per pass, and
// the three-stage update unit shared by all rows. A full output register holds S_DONE.
// Reset: control and config registers return to defaults; factor RAMs are not cleared.
// ----------------------------------------------------------------------------
// bpr_factor_sgd_update
// BPR matrix-factorization SGD step over user and item factor RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bpr_factor_sgd_update_assert.svh"

module bpr_factor_sgd_update #(
  parameter int NUM_USERS  = bfs_pkg::NUM_USERS_DEF,
  parameter int NUM_ITEMS  = bfs_pkg::NUM_ITEMS_DEF,
  parameter int FACTOR_DIM = bfs_pkg::FACTOR_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // func[2:0] user[12:3] pos_item[24:13] neg_item[36:25] elem_index[40:37]
  // write_value[56:41]
  input  wire logic [bfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // read_value[15:0] score_diff[31:16] inverted[32]
  output logic      [bfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int UA_W  = $clog2(NUM_USERS * FACTOR_DIM);
  localparam int IA_W  = $clog2(NUM_ITEMS * FACTOR_DIM);
  localparam int IW    = (FACTOR_DIM > 1) ? $clog2(FACTOR_DIM) : 1;
  localparam int ACC_W = 33 + $clog2(FACTOR_DIM);
  // reciprocals of the table sizes, scaled by 2^24
  localparam logic [23:0] MU = 24'((64'd1 << 24) / NUM_USERS);
  localparam logic [23:0] MI = 24'((64'd1 << 24) / NUM_ITEMS);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-32768);

  bfs_pkg::state_t state, state_next;
  bfs_pkg::mode_t  mode;

  logic [15:0] learn_rate, user_reg, item_reg;
  logic [14:0] margin;

  logic [2:0]  func;
  logic [9:0]  urow;
  logic [11:0] prow, nrow;
  logic [9:0]  uquo;
  logic [11:0] pquo, nquo;
  logic [3:0]  elem;
  logic [15:0] wval;
  logic [3:0]  bcnt;
  logic [UA_W-1:0] ubase;
  logic [IA_W-1:0] pbase, nbase;
  logic [IW-1:0]   idx;
  logic            last, e_ok;

  logic signed [15:0] u_q, p_q, n_q;
  logic signed [31:0] prodp, prodn;
  logic signed [ACC_W-1:0] pos, neg, diff;
  logic signed [15:0] dsat;
  logic [16:0] tk_q;
  logic [28:0] sprod;
  logic signed [17:0] coef;

  logic [15:0] res_read, res_diff;
  logic        res_inv;
  logic        out_load;

  logic            user_we, item_we;
  logic [UA_W-1:0] user_waddr, user_raddr;
  logic [IA_W-1:0] item_waddr, item_raddr;
  logic [15:0]     user_wdata, item_wdata, user_rd, item_rd;

  logic signed [16:0] mv_x;
  logic signed [15:0] mv_w, mv_new;
  logic        [15:0] mv_rg;

  logic [UA_W-1:0] ua, ua_e;
  logic [IA_W-1:0] pa, na, pa_e;

  assign s_axis_tready = (state == bfs_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign last = (idx == IW'(FACTOR_DIM - 1));
  assign e_ok = (32'(elem) < FACTOR_DIM);
  assign ua   = ubase + UA_W'(idx);
  assign pa   = pbase + IA_W'(idx);
  assign na   = nbase + IA_W'(idx);
  assign ua_e = ubase + UA_W'(elem);
  assign pa_e = pbase + IA_W'(elem);
  assign out_load = (state == bfs_pkg::S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= bfs_pkg::LEARN_RATE_RST;
      user_reg   <= bfs_pkg::USER_REG_RST;
      item_reg   <= bfs_pkg::ITEM_REG_RST;
      margin     <= bfs_pkg::MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfs_pkg::REG_LEARN_RATE: learn_rate <= cfg_data;
        bfs_pkg::REG_USER_REG:   user_reg   <= cfg_data;
        bfs_pkg::REG_ITEM_REG:   item_reg   <= cfg_data;
        bfs_pkg::REG_MARGIN:     margin     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfs_pkg::S_IDLE:   if (s_axis_tvalid) state_next = bfs_pkg::S_WRAP;
      bfs_pkg::S_WRAP:   if (bcnt == 4'd0) state_next = bfs_pkg::S_BASE;
      bfs_pkg::S_BASE: begin
        unique case (func) inside
          bfs_pkg::FUNC_TRAIN: state_next = bfs_pkg::S_DOT_A;
          bfs_pkg::FUNC_LOAD_USER, bfs_pkg::FUNC_LOAD_ITEM: state_next = bfs_pkg::S_LOAD;
          bfs_pkg::FUNC_READ_USER, bfs_pkg::FUNC_READ_ITEM: state_next = bfs_pkg::S_READ;
          default: state_next = bfs_pkg::S_DONE;
        endcase
      end
      bfs_pkg::S_LOAD:   state_next = bfs_pkg::S_DONE;
      bfs_pkg::S_READ:   state_next = bfs_pkg::S_READ_W;
      bfs_pkg::S_READ_W: state_next = bfs_pkg::S_DONE;
      bfs_pkg::S_DOT_A:  state_next = bfs_pkg::S_DOT_B;
      bfs_pkg::S_DOT_B:  state_next = bfs_pkg::S_DOT_C;
      bfs_pkg::S_DOT_C:  state_next = bfs_pkg::S_DOT_D;
      bfs_pkg::S_DOT_D:  state_next = last ? bfs_pkg::S_DIFF : bfs_pkg::S_DOT_A;
      bfs_pkg::S_DIFF:   state_next = bfs_pkg::S_SAT;
      bfs_pkg::S_SAT:    state_next = bfs_pkg::S_SIGM;
      bfs_pkg::S_SIGM:   state_next = bfs_pkg::S_COEF;
      bfs_pkg::S_COEF:   state_next = bfs_pkg::S_UPD_A;
      bfs_pkg::S_UPD_A:  state_next = bfs_pkg::S_UPD_B;
      bfs_pkg::S_UPD_B:  state_next = bfs_pkg::S_UPD_C;
      bfs_pkg::S_UPD_C:  state_next = bfs_pkg::S_MV1;
      bfs_pkg::S_MV1:    state_next = bfs_pkg::S_MV2;
      bfs_pkg::S_MV2:    state_next = bfs_pkg::S_MV3;
      bfs_pkg::S_MV3:    state_next = bfs_pkg::S_MVW;
      bfs_pkg::S_MVW: begin
        unique case (mode)
          bfs_pkg::MODE_USER: state_next = last ? bfs_pkg::S_ITM_A : bfs_pkg::S_UPD_A;
          bfs_pkg::MODE_POS:  state_next = bfs_pkg::S_ITM_N;
          default:            state_next = last ? bfs_pkg::S_DONE : bfs_pkg::S_ITM_A;
        endcase
      end
      bfs_pkg::S_ITM_A:  state_next = bfs_pkg::S_ITM_B;
      bfs_pkg::S_ITM_B:  state_next = bfs_pkg::S_MV1;
      bfs_pkg::S_ITM_N:  state_next = bfs_pkg::S_ITM_NB;
      bfs_pkg::S_ITM_NB: state_next = bfs_pkg::S_MV1;
      bfs_pkg::S_DONE:   if (out_load) state_next = bfs_pkg::S_IDLE;
      default:           state_next = bfs_pkg::S_IDLE;
    endcase
  end

  // ---------------- RAM control
  // Accesses to one entry never overlap: every write lands before the next read
  // of the same row is issued, including the same positive and negative item.
  always_comb begin
    user_we    = 1'b0;
    item_we    = 1'b0;
    user_waddr = ua;
    item_waddr = pa;
    user_wdata = mv_new;
    item_wdata = mv_new;
    user_raddr = ua;
    item_raddr = pa;
    unique case (state) inside
      bfs_pkg::S_LOAD: begin
        user_waddr = ua_e;
        item_waddr = pa_e;
        user_wdata = wval;
        item_wdata = wval;
        user_we    = e_ok && (func == bfs_pkg::FUNC_LOAD_USER);
        item_we    = e_ok && (func == bfs_pkg::FUNC_LOAD_ITEM);
      end
      bfs_pkg::S_READ: begin
        user_raddr = ua_e;
        item_raddr = pa_e;
      end
      bfs_pkg::S_DOT_B, bfs_pkg::S_UPD_B, bfs_pkg::S_ITM_N: item_raddr = na;
      bfs_pkg::S_MVW: begin
        user_we    = (mode == bfs_pkg::MODE_USER);
        item_we    = (mode != bfs_pkg::MODE_USER);
        item_waddr = (mode == bfs_pkg::MODE_NEG) ? na : pa;
      end
      default: ;
    endcase
  end

  // ---------------- update operands
  always_comb begin
    unique case (mode)
      bfs_pkg::MODE_USER: begin
        mv_x  = 17'(p_q) - 17'(n_q);
        mv_w  = u_q;
        mv_rg = user_reg;
      end
      bfs_pkg::MODE_POS: begin
        mv_x  = 17'(u_q);
        mv_w  = p_q;
        mv_rg = item_reg;
      end
      default: begin
        mv_x  = -17'(u_q);
        mv_w  = n_q;
        mv_rg = item_reg;
      end
    endcase
  end

  // ---------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bfs_pkg::S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- datapath
  always_ff @(posedge clk) begin
    logic [35:0]     uq_full, pq_full, nq_full;
    logic [16:0]     tk, tk1, gv;
    logic [15:0]     off;
    logic signed [ACC_W:0] mchk;
    uq_full = 36'(urow) * MU;
    pq_full = 36'(prow) * MI;
    nq_full = 36'(nrow) * MI;
    off    = {~dsat[15], dsat[14:0]};
    tk     = bfs_pkg::sig_tab({1'b0, off[15:12]});
    tk1    = bfs_pkg::sig_tab({1'b0, off[15:12]} + 5'd1);
    gv     = tk_q - 17'(sprod >> 12);
    mchk   = (ACC_W+1)'(diff) + $signed((ACC_W+1)'({margin, 12'b0}));
    unique case (state) inside
      bfs_pkg::S_IDLE: begin
        func <= s_axis_tdata[2:0];
        urow <= s_axis_tdata[12:3];
        prow <= s_axis_tdata[24:13];
        nrow <= s_axis_tdata[36:25];
        elem <= s_axis_tdata[40:37];
        wval <= s_axis_tdata[56:41];
        bcnt <= 4'd2;
      end
      bfs_pkg::S_WRAP: begin
        // row index modulo table size: reciprocal quotient estimate (low by at most
        // one), back-multiply and subtract, then one correcting subtract
        if (bcnt == 4'd2) begin
          uquo <= uq_full[33:24];
          pquo <= pq_full[35:24];
          nquo <= nq_full[35:24];
        end else if (bcnt == 4'd1) begin
          urow <= urow - 10'(32'(uquo) * 32'(NUM_USERS));
          prow <= prow - 12'(32'(pquo) * 32'(NUM_ITEMS));
          nrow <= nrow - 12'(32'(nquo) * 32'(NUM_ITEMS));
        end else begin
          if (32'(urow) >= 32'(NUM_USERS)) urow <= urow - 10'(NUM_USERS);
          if (32'(prow) >= 32'(NUM_ITEMS)) prow <= prow - 12'(NUM_ITEMS);
          if (32'(nrow) >= 32'(NUM_ITEMS)) nrow <= nrow - 12'(NUM_ITEMS);
        end
        bcnt <= bcnt - 4'd1;
      end
      bfs_pkg::S_BASE: begin
        ubase    <= UA_W'(urow) * UA_W'(FACTOR_DIM);
        pbase    <= IA_W'(prow) * IA_W'(FACTOR_DIM);
        nbase    <= IA_W'(nrow) * IA_W'(FACTOR_DIM);
        idx      <= '0;
        pos      <= '0;
        neg      <= '0;
        res_read <= '0;
        res_diff <= '0;
        res_inv  <= 1'b0;
      end
      bfs_pkg::S_READ_W: begin
        if (e_ok) res_read <= (func == bfs_pkg::FUNC_READ_USER) ? user_rd : item_rd;
      end
      bfs_pkg::S_DOT_B, bfs_pkg::S_UPD_B, bfs_pkg::S_ITM_B: begin
        u_q <= user_rd;
        p_q <= item_rd;
        if (state == bfs_pkg::S_ITM_B) mode <= bfs_pkg::MODE_POS;
      end
      bfs_pkg::S_DOT_C: begin
        n_q   <= item_rd;
        prodp <= u_q * p_q;
        prodn <= u_q * $signed(item_rd);
      end
      bfs_pkg::S_DOT_D: begin
        pos <= pos + ACC_W'(prodp);
        neg <= neg + ACC_W'(prodn);
        idx <= last ? '0 : idx + IW'(1);
      end
      bfs_pkg::S_DIFF: diff <= pos - neg;
      bfs_pkg::S_SAT: begin
        if ((diff >>> 12) > SMAX) dsat <= 16'sh7fff;
        else if ((diff >>> 12) < SMIN) dsat <= 16'sh8000;
        else dsat <= 16'(diff >>> 12);
        res_inv <= (mchk < 0);
      end
      bfs_pkg::S_SIGM: begin
        res_diff <= dsat;
        tk_q     <= tk;
        sprod    <= 29'(tk - tk1) * 29'(off[11:0]);
      end
      bfs_pkg::S_COEF: coef <= -$signed({1'b0, gv});
      bfs_pkg::S_UPD_C: begin
        n_q  <= item_rd;
        mode <= bfs_pkg::MODE_USER;
      end
      bfs_pkg::S_ITM_NB: begin
        n_q  <= item_rd;
        mode <= bfs_pkg::MODE_NEG;
      end
      bfs_pkg::S_MVW: begin
        if (mode == bfs_pkg::MODE_USER || mode == bfs_pkg::MODE_NEG) begin
          idx <= last ? '0 : idx + IW'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_axis_tdata <= {7'b0, res_inv, res_diff, res_read};
    end
  end

  // ---------------- instances
  bfs_ram #(.WIDTH(16), .DEPTH(NUM_USERS * FACTOR_DIM)) u_user_ram (
    .clk   (clk),
    .we    (user_we),
    .waddr (user_waddr),
    .wdata (user_wdata),
    .raddr (user_raddr),
    .rdata (user_rd)
  );

  bfs_ram #(.WIDTH(16), .DEPTH(NUM_ITEMS * FACTOR_DIM)) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_waddr),
    .wdata (item_wdata),
    .raddr (item_raddr),
    .rdata (item_rd)
  );

  bfs_move u_move (
    .clk   (clk),
    .coef  (coef),
    .x     (mv_x),
    .w     (mv_w),
    .rg    (mv_rg),
    .lr    (learn_rate),
    .w_new (mv_new)
  );

  // ---------------- assertions
  `BFS_ASSERT_NEVER(a_one_ram_write, user_we && item_we, "both factor RAMs written at once")
  `BFS_ASSERT_IMP(a_idle_no_write, state == bfs_pkg::S_IDLE, !user_we && !item_we,
    "factor RAM written while idle")
  `BFS_ASSERT_IMP(a_out_free, out_load, !m_axis_tvalid || m_axis_tready,
    "result overwrote a pending output")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - BPR factor SGD update testbench
// Preloads a pool of factor rows, then walks a directed table and random
// train/load/read and unused-func traffic over several register settings. A behavioral
// predictor tracks both factor tables; every result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = bfs_pkg::FACTOR_DIM_DEF;

  typedef struct {
    logic [2:0]  func;
    logic [9:0]  user;
    logic [11:0] pos;
    logic [11:0] neg;
    logic [3:0]  elem;
    logic [15:0] wv;
  } req_t;

  typedef struct {
    logic [15:0] rd;
    logic [15:0] score;
    logic        inv;
  } res_t;

  typedef struct {
    req_t r;
    bit   typed;
    res_t x;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [bfs_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [bfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bpr_factor_sgd_update i_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // predictor state
  shortint user_tab [bfs_pkg::NUM_USERS_DEF*DIM];
  shortint item_tab [bfs_pkg::NUM_ITEMS_DEF*DIM];
  bit      user_set [bfs_pkg::NUM_USERS_DEF*DIM];
  bit      item_set [bfs_pkg::NUM_ITEMS_DEF*DIM];
  longint  lr_q = bfs_pkg::LEARN_RATE_RST, ureg_q = bfs_pkg::USER_REG_RST;
  longint  ireg_q = bfs_pkg::ITEM_REG_RST;
  longint  margin_q = bfs_pkg::MARGIN_RST;

  res_t pending_results[$];
  int   errors = 0;
  bit   sender_gaps = 1'b1;
  bit   hold_req = 1'b0;

  localparam longint SIG_PTS [17] = '{65514, 65476, 65374, 65097, 64357, 62428,
    57724, 47911, 32768, 17625, 7812, 3108, 1179, 439, 162, 60, 22};

  // pools of fully loaded rows; trains only touch these
  int user_pool [5] = '{0, 1, 2, 3, 1023};
  int item_pool [7] = '{0, 1, 2, 3, 4, 5, 4095};

  function automatic longint sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic shortint sgd_step(longint w, longint term, longint decay);
    longint g, delta;
    g = term + 2 * decay * w;
    delta = (lr_q * g + (64'sd1 <<< 31)) >>> 32;
    return shortint'(sat16(w - delta));
  endfunction

  task automatic apply_request(input req_t r, output res_t o);
    int ub, pb, nb, e;
    longint pos_dot, neg_dot, diff, d, off, k, f, c, cu;
    ub = int'(r.user) * DIM;
    pb = int'(r.pos) * DIM;
    nb = int'(r.neg) * DIM;
    e = r.elem;
    o = '{16'd0, 16'd0, 1'b0};
    case (r.func)
      bfs_pkg::FUNC_TRAIN: begin
        pos_dot = 0;
        neg_dot = 0;
        for (int i = 0; i < DIM; i++) begin
          pos_dot += longint'(user_tab[ub+i]) * item_tab[pb+i];
          neg_dot += longint'(user_tab[ub+i]) * item_tab[nb+i];
        end
        diff = pos_dot - neg_dot;
        d = sat16(diff >>> 12);
        o.score = d[15:0];
        o.inv = (-diff > margin_q * 4096);
        off = d + 32768;
        k = off >> 12;
        f = off & 4095;
        c = -(SIG_PTS[k] - (((SIG_PTS[k] - SIG_PTS[k+1]) * f) >>> 12));
        for (int i = 0; i < DIM; i++)
          user_tab[ub+i] = sgd_step(user_tab[ub+i],
                                    c * (longint'(item_tab[pb+i]) - item_tab[nb+i]), ureg_q);
        for (int i = 0; i < DIM; i++) begin
          cu = c * user_tab[ub+i];
          item_tab[pb+i] = sgd_step(item_tab[pb+i], cu, ireg_q);
          item_tab[nb+i] = sgd_step(item_tab[nb+i], -cu, ireg_q);
        end
      end
      bfs_pkg::FUNC_LOAD_USER: begin
        user_tab[ub+e] = shortint'(r.wv);
        user_set[ub+e] = 1'b1;
      end
      bfs_pkg::FUNC_LOAD_ITEM: begin
        item_tab[pb+e] = shortint'(r.wv);
        item_set[pb+e] = 1'b1;
      end
      bfs_pkg::FUNC_READ_USER: o.rd = user_tab[ub+e];
      bfs_pkg::FUNC_READ_ITEM: o.rd = item_tab[pb+e];
      default: ;
    endcase
  endtask

  // typed rows queue their own expectation; the predictor still tracks state
  task automatic send_request(input req_t r, input bit typed, input res_t x);
    res_t p;
    if (sender_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) @(negedge clk);
    s_axis_tdata = {7'd0, r.wv, r.elem, r.neg, r.pos, r.user, r.func};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_request(r, p);
    if (typed) p = x;
    pending_results = {pending_results, p};
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [bfs_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bfs_pkg::REG_LEARN_RATE: lr_q = val;
      bfs_pkg::REG_USER_REG:   ureg_q = val;
      bfs_pkg::REG_ITEM_REG:   ireg_q = val;
      default:                 margin_q = val[14:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic req_t noise_fields();
    req_t r;
    r.func = 3'($urandom_range(0, 7));
    r.user = 10'($urandom);
    r.pos = 12'($urandom);
    r.neg = 12'($urandom);
    r.elem = 4'($urandom);
    r.wv = 16'($urandom);
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    r = noise_fields();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.func = bfs_pkg::FUNC_TRAIN;
      r.user = 10'(user_pool[$urandom_range(0, 4)]);
      r.pos = 12'(item_pool[$urandom_range(0, 6)]);
      r.neg = ($urandom_range(0, 9) == 0) ? r.pos : 12'(item_pool[$urandom_range(0, 6)]);
    end else if (pick < 75) begin
      r.func = $urandom_range(0, 1) ? bfs_pkg::FUNC_LOAD_USER : bfs_pkg::FUNC_LOAD_ITEM;
      if ($urandom_range(0, 1)) begin
        r.user = 10'(user_pool[$urandom_range(0, 4)]);
        r.pos = 12'(item_pool[$urandom_range(0, 6)]);
      end
      if ($urandom_range(0, 3) == 0) r.wv = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      else if ($urandom_range(0, 1)) r.wv = 16'(shortint'($urandom_range(0, 8191)) - 4096);
    end else if (pick < 92) begin
      r.func = $urandom_range(0, 1) ? bfs_pkg::FUNC_READ_USER : bfs_pkg::FUNC_READ_ITEM;
      if (r.func == bfs_pkg::FUNC_READ_USER && !user_set[int'(r.user)*DIM + r.elem])
        r.user = 10'(user_pool[$urandom_range(0, 4)]);
      if (r.func == bfs_pkg::FUNC_READ_ITEM && !item_set[int'(r.pos)*DIM + r.elem])
        r.pos = 12'(item_pool[$urandom_range(0, 6)]);
    end else begin
      r.func = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  task automatic random_phase(input int n);
    res_t none;
    none = '{16'd0, 16'd0, 1'b0};
    repeat (n) send_request(random_request(), 1'b0, none);
  endtask

  task automatic preload_pools();
    req_t r;
    res_t none;
    none = '{16'd0, 16'd0, 1'b0};
    r = noise_fields();
    foreach (user_pool[u])
      for (int e = 0; e < DIM; e++) begin
        r.func = bfs_pkg::FUNC_LOAD_USER;
        r.user = 10'(user_pool[u]);
        r.elem = 4'(e);
        r.wv = (user_pool[u] == 1023) ? 16'h7fff : 16'(shortint'($urandom_range(0, 8191)) - 4096);
        send_request(r, 1'b0, none);
      end
    foreach (item_pool[p])
      for (int e = 0; e < DIM; e++) begin
        r.func = bfs_pkg::FUNC_LOAD_ITEM;
        r.pos = 12'(item_pool[p]);
        r.elem = 4'(e);
        r.wv = (item_pool[p] == 4095) ? 16'h8000 :
               (item_pool[p] == 0) ? 16'h7fff : 16'(shortint'($urandom_range(0, 8191)) - 4096);
        send_request(r, 1'b0, none);
      end
  endtask

  function automatic row_t mk(input logic [2:0] fn, input int u, input int p, input int n,
                              input int e, input logic [15:0] wv, input bit typed,
                              input logic [15:0] rd, input logic [15:0] sc, input bit inv);
    row_t t;
    t.r = '{fn, 10'(u), 12'(p), 12'(n), 4'(e), wv};
    t.typed = typed;
    t.x = '{rd, sc, inv};
    return t;
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result exp none got %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== want.rd) begin
          $display("%0t: read_value exp %h got %h", $realtime, want.rd, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[31:16] !== want.score) begin
          $display("%0t: score_diff exp %h got %h", $realtime, want.score, m_axis_tdata[31:16]);
          errors++;
        end
        if (m_axis_tdata[32] !== want.inv) begin
          $display("%0t: inverted exp %b got %b", $realtime, want.inv, m_axis_tdata[32]);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_req && !hold_done) begin
      hold_left = 2000;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else if (rx_cycle & 1024) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t rows[$];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    preload_pools();

    // directed part: unused funcs, extreme loads and reads, saturating and plain trains
    rows = {rows, mk(3'd5, 1023, 4095, 4095, 15, 16'hffff, 1, 16'h0, 16'h0, 0)};
    rows = {rows, mk(3'd6, 0, 0, 0, 0, 16'h0, 1, 16'h0, 16'h0, 0)};
    rows = {rows, mk(3'd7, 512, 2048, 1, 8, 16'h5555, 1, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_LOAD_USER, 1023, 0, 4095, 15, 16'h7fff, 1,
                     16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_READ_USER, 1023, 4095, 0, 15, 16'hffff, 1,
                     16'h7fff, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_LOAD_ITEM, 0, 4095, 0, 0, 16'h8000, 1, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_READ_ITEM, 0, 4095, 0, 0, 16'h0, 1, 16'h8000, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_LOAD_USER, 0, 0, 0, 0, 16'h0, 1, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_READ_USER, 0, 0, 0, 0, 16'h0, 1, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_LOAD_ITEM, 1023, 2730, 1365, 7, 16'h1234, 1,
                     16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_READ_ITEM, 0, 2730, 0, 7, 16'h0, 1, 16'h1234, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_TRAIN, 1023, 4095, 0, 0, 16'h0, 1, 16'h0, 16'h8000, 1)};
    rows = {rows, mk(bfs_pkg::FUNC_TRAIN, 1023, 0, 4095, 0, 16'h0, 1, 16'h0, 16'h7fff, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_TRAIN, 1, 2, 2, 0, 16'h0, 0, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_TRAIN, 0, 1, 3, 0, 16'h0, 0, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_TRAIN, 2, 4, 5, 0, 16'h0, 0, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_READ_USER, 1, 0, 0, 3, 16'h0, 0, 16'h0, 16'h0, 0)};
    rows = {rows, mk(bfs_pkg::FUNC_READ_ITEM, 0, 2, 0, 9, 16'h0, 0, 16'h0, 16'h0, 0)};
    foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].x);
    random_phase(40);
    drain();

    write_reg(bfs_pkg::REG_LEARN_RATE, 16'hffff);
    write_reg(bfs_pkg::REG_USER_REG, 16'h0);
    write_reg(bfs_pkg::REG_ITEM_REG, 16'h0);
    write_reg(bfs_pkg::REG_MARGIN, 16'h7fff);
    sender_gaps = 1'b0;
    random_phase(50);
    drain();

    write_reg(bfs_pkg::REG_LEARN_RATE, 16'h0);
    write_reg(bfs_pkg::REG_USER_REG, 16'hffff);
    write_reg(bfs_pkg::REG_ITEM_REG, 16'hffff);
    write_reg(bfs_pkg::REG_MARGIN, 16'h0);
    sender_gaps = 1'b1;
    hold_req = 1'b1;
    random_phase(50);
    drain();

    write_reg(bfs_pkg::REG_LEARN_RATE, 16'($urandom_range(0, 65535)));
    write_reg(bfs_pkg::REG_USER_REG, 16'($urandom_range(0, 65535)));
    write_reg(bfs_pkg::REG_ITEM_REG, 16'($urandom_range(0, 65535)));
    write_reg(bfs_pkg::REG_MARGIN, 16'($urandom_range(0, 32767)));
    random_phase(50);
    drain();

    write_reg(bfs_pkg::REG_LEARN_RATE, 16'($urandom_range(100, 4000)));
    write_reg(bfs_pkg::REG_USER_REG, 16'($urandom_range(0, 2000)));
    write_reg(bfs_pkg::REG_ITEM_REG, 16'($urandom_range(0, 2000)));
    write_reg(bfs_pkg::REG_MARGIN, 16'($urandom_range(0, 64)));
    random_phase(50);
    drain();

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
